FILE: design/hmq_pkg.sv
// ============================================================================
// hmq_pkg
// Shared types and constants for the heightmap height query unit.
// ============================================================================
`default_nettype none

package hmq_pkg;

  // Width of a height sample and of a Q16.16 position or tile size.
  localparam int SAMPLE_W = 32;
  localparam int POS_W    = 32;

  // Shared divider: dividend, divisor and step count widths.
  localparam int DIV_W  = 65;
  localparam int DVS_W  = 33;
  localparam int STEP_W = 7;

  // Steps for a position divide and for the final rounding divide.
  localparam logic [STEP_W-1:0] POS_STEPS = 7'd32;
  localparam logic [STEP_W-1:0] FIN_STEPS = 7'd65;

  // Request kinds carried in in_tuser.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic [0:0] CFG_TILE_SIZE    = 1'b0;
  localparam logic [0:0] CFG_TILES_IN_USE = 1'b1;

  // Input tdata layout, lowest field first.
  localparam int IN_TDATA_W = 112;
  localparam int COL_LO     = 0;
  localparam int ROW_LO     = 7;
  localparam int HGT_LO     = 14;
  localparam int QX_LO      = 46;
  localparam int QZ_LO      = 78;

  // Query sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVX,
    ST_DIVZ,
    ST_ADDR,
    ST_MAC,
    ST_ROUND,
    ST_DIVF,
    ST_OUT
  } hmq_state_t;

  // Divider launch control.
  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_ctl_t;

  // Divider status.
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

`default_nettype wire

FILE: design/hmq_ram.sv
// ============================================================================
// hmq_ram
// Generic single-port synchronous RAM with a registered read.
// ============================================================================
`default_nettype none

module hmq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4225
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // Write when enabled, otherwise register the read word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

FILE: design/hmq_div.sv
// ============================================================================
// hmq_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ============================================================================
`default_nettype none

module hmq_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire hmq_pkg::div_ctl_t           ctl,
  input  wire logic [hmq_pkg::DIV_W-1:0]   dividend,
  input  wire logic [hmq_pkg::DVS_W-1:0]   divisor,
  output      hmq_pkg::div_sts_t           sts,
  output      logic [hmq_pkg::DIV_W-1:0]   quotient,
  output      logic [hmq_pkg::DVS_W-1:0]   remainder
);

  // The dividend is consumed from the top bit; quotient bits enter at the bottom.
  logic [hmq_pkg::DIV_W-1:0]  dvd_r;
  logic [hmq_pkg::DVS_W-1:0]  rem_r;
  logic [hmq_pkg::DVS_W-1:0]  dvs_r;
  logic [hmq_pkg::STEP_W-1:0] cnt_r;
  logic                       busy_r;
  logic                       done_r;

  logic [hmq_pkg::DVS_W:0]    trial;
  logic                       fits;

  // One trial subtraction per cycle.
  assign trial = {rem_r, dvd_r[hmq_pkg::DIV_W-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= ctl.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == hmq_pkg::STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[hmq_pkg::DIV_W-2:0], fits};
      if (fits) begin
        rem_r <= hmq_pkg::DVS_W'(trial - {1'b0, dvs_r});
      end else begin
        rem_r <= trial[hmq_pkg::DVS_W-1:0];
      end
    end
  end

  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign quotient  = dvd_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

FILE: design/heightmap_height_query_unit.sv
// ============================================================================
// heightmap_height_query_unit
// Height grid store with planar triangle interpolation of query points.
// ============================================================================
//
//  channel | direction | contents
//  --------+-----------+---------------------------------------------------
//  cfg_*   | in        | register writes: tile_size (0), tiles_in_use (1)
//  in_*    | in        | request: sample write or height query
//  out_*   | out       | one result per query: height and range flag
//
// A sample write writes the grid memory in the cycle it is taken, if its cell lies in the grid.
// A query runs through the shared bit-serial divider:
// 32 steps each for x and z, three memory reads through one port feeding
// one multiplier, then 65 steps for the rounding divide.
// A query that falls off the grid finishes after its position divide.
// Reset is synchronous, clears control state and loads the configuration defaults; the grid is undefined.
// A finished result waits in the output register while a new request is taken.
// ============================================================================
`default_nettype none

module heightmap_height_query_unit #(
  parameter int MAX_TILES = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // Configuration write port.
  input  wire logic         cfg_we,
  input  wire logic [0:0]   cfg_addr,
  input  wire logic [31:0]  cfg_wdata,
  // Request channel.
  input  wire logic         in_tvalid,
  output      logic         in_tready,
  // cell_col[6:0], cell_row[13:7], sample_height[45:14], query_x[77:46],
  // query_z[109:78], zero pad [111:110]
  input  wire logic [111:0] in_tdata,
  // req_type[0]
  input  wire logic [0:0]   in_tuser,
  // Result channel.
  output      logic         out_tvalid,
  input  wire logic         out_tready,
  // height_out[31:0]
  output      logic [31:0]  out_tdata,
  // out_of_range[0]
  output      logic [0:0]   out_tuser
);

  localparam int SIDE  = MAX_TILES + 1;
  localparam int DEPTH = SIDE * SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = $clog2(SIDE);

  localparam logic signed [65:0] Q_MAX = 66'sd2147483647;
  localparam logic signed [65:0] Q_MIN = -66'sd2147483648;

  // Request fields.
  logic                               in_req;
  logic [6:0]                         in_col;
  logic [6:0]                         in_row;
  logic [hmq_pkg::SAMPLE_W-1:0]       in_height;
  logic [hmq_pkg::POS_W-1:0]          in_x;
  logic [hmq_pkg::POS_W-1:0]          in_z;

  assign in_req    = in_tuser[0];
  assign in_col    = in_tdata[hmq_pkg::COL_LO +: 7];
  assign in_row    = in_tdata[hmq_pkg::ROW_LO +: 7];
  assign in_height = in_tdata[hmq_pkg::HGT_LO +: hmq_pkg::SAMPLE_W];
  assign in_x      = in_tdata[hmq_pkg::QX_LO +: hmq_pkg::POS_W];
  assign in_z      = in_tdata[hmq_pkg::QZ_LO +: hmq_pkg::POS_W];

  // Configuration registers.
  logic [31:0] tile_size_r;
  logic [6:0]  tiles_in_use_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_size_r    <= 32'd65536;
      tiles_in_use_r <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        hmq_pkg::CFG_TILE_SIZE:    tile_size_r    <= cfg_wdata;
        hmq_pkg::CFG_TILES_IN_USE: tiles_in_use_r <= cfg_wdata[6:0];
      endcase
    end
  end

  // Effective tile count, clamped to 1..MAX_TILES.
  logic [31:0] n_eff;

  always_comb begin
    priority if (tiles_in_use_r == 7'd0) begin
      n_eff = 32'd1;
    end else if (32'(tiles_in_use_r) > 32'(MAX_TILES)) begin
      n_eff = 32'(MAX_TILES);
    end else begin
      n_eff = 32'(tiles_in_use_r);
    end
  end

  // Sequencer and datapath registers.
  hmq_pkg::hmq_state_t state_r, state_nxt;
  logic [hmq_pkg::POS_W-1:0]  qz_r, qz_nxt;
  logic [TW-1:0]              tx_r, tx_nxt;
  logic [TW-1:0]              tz_r, tz_nxt;
  logic [31:0]                rx_r, rx_nxt;
  logic [31:0]                rz_r, rz_nxt;
  logic [AW-1:0]              a_r [0:2];
  logic [AW-1:0]              a_nxt [0:2];
  logic [31:0]                w_r [0:2];
  logic [31:0]                w_nxt [0:2];
  logic [2:0]                 cnt_r, cnt_nxt;
  logic signed [63:0]         prod_r, prod_nxt;
  logic signed [63:0]         acc_r, acc_nxt;
  logic                       neg_r, neg_nxt;
  logic [31:0]                res_height_r, res_height_nxt;
  logic                       res_oor_r, res_oor_nxt;
  logic                       out_tvalid_r;
  logic [31:0]                out_height_r;
  logic                       out_oor_r;
  logic                       out_load;

  // Memory and divider hookup.
  logic                          ram_we;
  logic [AW-1:0]                 ram_addr;
  logic [hmq_pkg::SAMPLE_W-1:0]  ram_rdata;
  hmq_pkg::div_ctl_t             div_ctl;
  hmq_pkg::div_sts_t             div_sts;
  logic [hmq_pkg::DIV_W-1:0]     div_dividend;
  logic [hmq_pkg::DVS_W-1:0]     div_divisor;
  logic [hmq_pkg::DIV_W-1:0]     div_quot;
  logic [hmq_pkg::DVS_W-1:0]     div_rem;

  hmq_ram #(
    .WIDTH (hmq_pkg::SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_height),
    .rdata (ram_rdata)
  );

  hmq_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (div_ctl),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .sts       (div_sts),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // Tile location from a finished position divide.
  logic [31:0] pos_q;
  logic [31:0] pos_r;
  logic        pos_oor;
  logic        pos_edge;
  logic [31:0] pos_tile;
  logic [31:0] pos_rem;

  assign pos_q    = div_quot[31:0];
  assign pos_r    = div_rem[31:0];
  assign pos_edge = (pos_q == n_eff);
  assign pos_oor  = (pos_q > n_eff) || (pos_edge && (pos_r != 32'd0));
  assign pos_tile = pos_edge ? (n_eff - 32'd1) : pos_q;
  assign pos_rem  = pos_edge ? tile_size_r : pos_r;

  // Grid addresses and triangle weights.
  logic [31:0] wr_addr32;
  logic [31:0] base32;
  logic [32:0] rsum;
  logic        lower_tri;

  assign wr_addr32 = 32'(in_row) * 32'(SIDE) + 32'(in_col);
  assign base32    = 32'(tz_r) * 32'(SIDE) + 32'(tx_r);
  assign rsum      = {1'b0, rx_r} + {1'b0, rz_r};
  assign lower_tri = (rsum < {1'b0, tile_size_r});

  // Multiplier: signed sample times unsigned weight.
  logic [1:0]         mul_idx;
  logic signed [64:0] mul_full;

  assign mul_idx  = 2'(cnt_r - 3'd1);
  assign mul_full = $signed(ram_rdata) * $signed({1'b0, w_r[mul_idx]});

  // Rounded numerator: floor((2*num + ts) / (2*ts)).
  logic [65:0]        num2;
  logic signed [65:0] qv;

  assign num2 = {acc_r[63], acc_r, 1'b0} + {34'd0, tile_size_r};
  assign qv   = neg_r ? $signed(~{1'b0, div_quot}) : $signed({1'b0, div_quot});

  // Next state and outputs of the sequencer.
  always_comb begin
    state_nxt      = state_r;
    qz_nxt         = qz_r;
    tx_nxt         = tx_r;
    tz_nxt         = tz_r;
    rx_nxt         = rx_r;
    rz_nxt         = rz_r;
    a_nxt          = a_r;
    w_nxt          = w_r;
    cnt_nxt        = cnt_r;
    prod_nxt       = prod_r;
    acc_nxt        = acc_r;
    neg_nxt        = neg_r;
    res_height_nxt = res_height_r;
    res_oor_nxt    = res_oor_r;
    ram_we         = 1'b0;
    ram_addr       = AW'(wr_addr32);
    div_ctl.start  = 1'b0;
    div_ctl.steps  = hmq_pkg::POS_STEPS;
    div_dividend   = {in_x, 33'd0};
    div_divisor    = {1'b0, tile_size_r};
    out_load       = 1'b0;

    unique case (state_r)
      hmq_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          if (in_req == hmq_pkg::REQ_WRITE) begin
            ram_we = (32'(in_col) <= 32'(MAX_TILES)) && (32'(in_row) <= 32'(MAX_TILES));
          end else if (tile_size_r == 32'd0) begin
            res_height_nxt = 32'd0;
            res_oor_nxt    = 1'b1;
            state_nxt      = hmq_pkg::ST_OUT;
          end else begin
            div_ctl.start = 1'b1;
            qz_nxt        = in_z;
            state_nxt     = hmq_pkg::ST_DIVX;
          end
        end
      end

      hmq_pkg::ST_DIVX: begin
        div_dividend = {qz_r, 33'd0};
        if (div_sts.done) begin
          tx_nxt = pos_tile[TW-1:0];
          rx_nxt = pos_rem;
          if (pos_oor) begin
            res_height_nxt = 32'd0;
            res_oor_nxt    = 1'b1;
            state_nxt      = hmq_pkg::ST_OUT;
          end else begin
            div_ctl.start = 1'b1;
            state_nxt     = hmq_pkg::ST_DIVZ;
          end
        end
      end

      hmq_pkg::ST_DIVZ: begin
        if (div_sts.done) begin
          tz_nxt = pos_tile[TW-1:0];
          rz_nxt = pos_rem;
          if (pos_oor) begin
            res_height_nxt = 32'd0;
            res_oor_nxt    = 1'b1;
            state_nxt      = hmq_pkg::ST_OUT;
          end else begin
            state_nxt = hmq_pkg::ST_ADDR;
          end
        end
      end

      hmq_pkg::ST_ADDR: begin
        // Three corners of the chosen triangle with their weights.
        if (lower_tri) begin
          a_nxt[0] = AW'(base32);
          w_nxt[0] = 32'({1'b0, tile_size_r} - rsum);
          a_nxt[1] = AW'(base32 + 32'd1);
          w_nxt[1] = rx_r;
          a_nxt[2] = AW'(base32 + 32'(SIDE));
          w_nxt[2] = rz_r;
        end else begin
          a_nxt[0] = AW'(base32 + 32'(SIDE) + 32'd1);
          w_nxt[0] = 32'(rsum - {1'b0, tile_size_r});
          a_nxt[1] = AW'(base32 + 32'(SIDE));
          w_nxt[1] = tile_size_r - rx_r;
          a_nxt[2] = AW'(base32 + 32'd1);
          w_nxt[2] = tile_size_r - rz_r;
        end
        cnt_nxt   = 3'd0;
        state_nxt = hmq_pkg::ST_MAC;
      end

      hmq_pkg::ST_MAC: begin
        // Read, multiply and accumulate overlap, each registered behind the one before.
        if (cnt_r < 3'd3) begin
          ram_addr = a_r[cnt_r[1:0]];
        end
        if (cnt_r >= 3'd1 && cnt_r <= 3'd3) begin
          prod_nxt = mul_full[63:0];
        end
        if (cnt_r == 3'd2) begin
          acc_nxt = prod_r;
        end else if (cnt_r > 3'd2) begin
          acc_nxt = acc_r + prod_r;
        end
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd4) begin
          state_nxt = hmq_pkg::ST_ROUND;
        end
      end

      hmq_pkg::ST_ROUND: begin
        // Negative numerators divide their complement, then complement back.
        div_ctl.start = 1'b1;
        div_ctl.steps = hmq_pkg::FIN_STEPS;
        div_divisor   = {tile_size_r, 1'b0};
        neg_nxt       = num2[65];
        div_dividend  = num2[65] ? ~num2[64:0] : num2[64:0];
        state_nxt     = hmq_pkg::ST_DIVF;
      end

      hmq_pkg::ST_DIVF: begin
        if (div_sts.done) begin
          priority if (qv > Q_MAX) begin
            res_height_nxt = Q_MAX[31:0];
          end else if (qv < Q_MIN) begin
            res_height_nxt = Q_MIN[31:0];
          end else begin
            res_height_nxt = qv[31:0];
          end
          res_oor_nxt = 1'b0;
          state_nxt   = hmq_pkg::ST_OUT;
        end
      end

      hmq_pkg::ST_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = hmq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = hmq_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= hmq_pkg::ST_IDLE;
      cnt_r        <= 3'd0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    qz_r         <= qz_nxt;
    tx_r         <= tx_nxt;
    tz_r         <= tz_nxt;
    rx_r         <= rx_nxt;
    rz_r         <= rz_nxt;
    a_r          <= a_nxt;
    w_r          <= w_nxt;
    prod_r       <= prod_nxt;
    acc_r        <= acc_nxt;
    neg_r        <= neg_nxt;
    res_height_r <= res_height_nxt;
    res_oor_r    <= res_oor_nxt;
    if (out_load) begin
      out_height_r <= res_height_r;
      out_oor_r    <= res_oor_r;
    end
  end

  assign in_tready    = (state_r == hmq_pkg::ST_IDLE);
  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_height_r;
  assign out_tuser[0] = out_oor_r;

  // Grid writes happen only between queries.
  a_we_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == hmq_pkg::ST_IDLE))
    else $error("grid write outside idle");

  // The divider is never restarted while it still works.
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctl.start |-> !div_sts.busy)
    else $error("divider restarted while busy");

  // A new request is taken only with the divider at rest.
  a_ready_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !div_sts.busy)
    else $error("request taken during a divide");

  // A result enters the output register only when it is free or draining.
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_tvalid_r || out_tready))
    else $error("result overwrote a pending one");

  // A divide finishes only while a divide state waits for it.
  a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == hmq_pkg::ST_DIVX || state_r == hmq_pkg::ST_DIVZ ||
                      state_r == hmq_pkg::ST_DIVF))
    else $error("divider finished with no waiting state");

endmodule

`default_nettype wire
